// ===== hdl/sme_pkg.sv =====
package sme_pkg;

   localparam int unsigned STACK_DEPTH_DEFAULT = 256;
   localparam int unsigned OPCODE_W = 8;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned DEPTH_W = 9;
   localparam int unsigned LIMIT_W = 9;
   localparam int unsigned STATUS_W = 3;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   localparam logic [OPCODE_W-1:0] OP_HALT = 8'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH = 8'd1;
   localparam logic [OPCODE_W-1:0] OP_POP  = 8'd2;
   localparam logic [OPCODE_W-1:0] OP_ADD  = 8'd3;
   localparam logic [OPCODE_W-1:0] OP_SUB  = 8'd4;
   localparam logic [OPCODE_W-1:0] OP_MUL  = 8'd5;
   localparam logic [OPCODE_W-1:0] OP_SHOW = 8'd6;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_HALTED  = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_FULL    = 3'd3,
      ST_UNKNOWN = 3'd4,
      ST_IGNORED = 3'd5
   } status_type;

   typedef struct packed {
      status_type               status;
      logic                     show_valid;
      logic signed [WORD_W-1:0] show_value;
      logic [DEPTH_W-1:0]       depth;
   } rsp_type;

endpackage

// ===== hdl/sme_req_if.sv =====
interface sme_req_if import sme_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [OPCODE_W-1:0]      opcode;
   logic signed [WORD_W-1:0] operand;

   modport source (output valid, opcode, operand, input ready);
   modport sink (input valid, opcode, operand, output ready);
endinterface

// ===== hdl/sme_rsp_if.sv =====
interface sme_rsp_if import sme_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic                     show_valid;
   logic signed [WORD_W-1:0] show_value;
   logic [DEPTH_W-1:0]       depth;

   modport source (output valid, status, show_valid, show_value, depth, input ready);
   modport sink (input valid, status, show_valid, show_value, depth, output ready);
endinterface

// ===== hdl/sme_stack.sv =====
module sme_stack import sme_pkg::*; #(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     exec,
   input  logic [OPCODE_W-1:0]      opcode,
   input  logic signed [WORD_W-1:0] operand,
   input  logic [LIMIT_W-1:0]       limit,
   output rsp_type                  result
);

   localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // The two top entries live in registers; the rest sit in the memory.
   // third_ff always holds the entry just below sec_ff so that a pop or a
   // binary operation can refill sec_ff in the same cycle.
   logic [WORD_W-1:0]  mem_ff [STACK_DEPTH];
   logic [WORD_W-1:0]  top_ff, top_in;
   logic [WORD_W-1:0]  sec_ff, sec_in;
   logic [WORD_W-1:0]  third_ff;
   logic [DEPTH_W-1:0] sp_ff, sp_in;
   logic               stopped_ff, stopped_in;
   logic               spill;
   logic [AddrW-1:0]   wr_addr;
   logic [AddrW-1:0]   rd_addr;
   logic [WORD_W-1:0]  alu_sum;
   logic [WORD_W-1:0]  alu_diff;
   logic [WORD_W-1:0]  alu_prod;
   logic [WORD_W-1:0]  alu_out;
   logic               full;
   status_type         status;

   assign alu_sum  = sec_ff + top_ff;
   assign alu_diff = sec_ff - top_ff;
   assign alu_prod = sec_ff * top_ff;

   always_comb begin
      case (opcode)
         OP_ADD:  alu_out = alu_sum;
         OP_SUB:  alu_out = alu_diff;
         default: alu_out = alu_prod;
      endcase
   end

   assign full = (32'(sp_ff) >= 32'(STACK_DEPTH)) || (sp_ff >= limit);

   always_comb begin
      status     = ST_OK;
      sp_in      = sp_ff;
      stopped_in = stopped_ff;
      top_in     = top_ff;
      sec_in     = sec_ff;
      spill      = 1'b0;
      result.show_valid = 1'b0;
      result.show_value = '0;
      if (exec) begin
         if (stopped_ff) begin
            status = ST_IGNORED;
         end else begin
            unique case (opcode) inside
               OP_HALT: begin
                  status = ST_HALTED;
               end
               OP_PUSH: begin
                  if (full) begin
                     status = ST_FULL;
                  end else begin
                     top_in = operand;
                     sec_in = top_ff;
                     sp_in  = sp_ff + DEPTH_W'(1);
                     spill  = (sp_ff >= DEPTH_W'(2));
                  end
               end
               OP_POP: begin
                  if (sp_ff == '0) begin
                     status = ST_EMPTY;
                  end else begin
                     top_in = sec_ff;
                     sec_in = third_ff;
                     sp_in  = sp_ff - DEPTH_W'(1);
                  end
               end
               OP_ADD, OP_SUB, OP_MUL: begin
                  if (sp_ff < DEPTH_W'(2)) begin
                     status = ST_EMPTY;
                  end else begin
                     top_in = alu_out;
                     sec_in = third_ff;
                     sp_in  = sp_ff - DEPTH_W'(1);
                  end
               end
               OP_SHOW: begin
                  if (sp_ff == '0) begin
                     status = ST_EMPTY;
                  end else begin
                     result.show_valid = 1'b1;
                     result.show_value = top_ff;
                  end
               end
               default: begin
                  status = ST_UNKNOWN;
               end
            endcase
            if (status != ST_OK) begin
               stopped_in = 1'b1;
            end
         end
      end
      result.status = status;
      result.depth  = sp_in;
   end

   assign wr_addr = AddrW'(sp_ff - DEPTH_W'(2));
   assign rd_addr = AddrW'(sp_in - DEPTH_W'(3));

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff      <= '0;
         stopped_ff <= 1'b0;
      end else begin
         sp_ff      <= sp_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      sec_ff <= sec_in;
      // A push spills the old second entry, which becomes the new third one.
      if (spill) begin
         mem_ff[wr_addr] <= sec_ff;
         third_ff        <= sec_ff;
      end else begin
         third_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/stack_machine_executor.sv =====
// A transferred request passes through the input register, then the result
// register. Throughput: one instruction per cycle unless the response channel
// stalls; the top two stack entries are held in registers and the memory is
// read one entry ahead, so no instruction waits on the memory port.
// Reset is synchronous: the stack empties, the machine leaves the stopped
// state and the limit returns to 256. The stack memory is not cleared.
module stack_machine_executor import sme_pkg::*; #(
   parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   sme_req_if.sink            req_chan,
   sme_rsp_if.source          rsp_chan,
   input  logic               csr_write_en,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   logic                     in_valid_ff;
   logic [OPCODE_W-1:0]      in_opcode_ff;
   logic signed [WORD_W-1:0] in_operand_ff;
   logic                     out_valid_ff;
   rsp_type                  rsp_ff;
   rsp_type                  result;
   logic [LIMIT_W-1:0]       limit_ff;
   logic                     advance;
   logic                     req_ready;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_ready = !in_valid_ff || advance;

   sme_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .exec    (advance),
      .opcode  (in_opcode_ff),
      .operand (in_operand_ff),
      .limit   (limit_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_ready) begin
         in_opcode_ff  <= req_chan.opcode;
         in_operand_ff <= req_chan.operand;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = rsp_ff.status;
   assign rsp_chan.show_valid = rsp_ff.show_valid;
   assign rsp_chan.show_value = rsp_ff.show_value;
   assign rsp_chan.depth      = rsp_ff.depth;

endmodule
